[src/icov_pkg.sv]
// Shared types and constants for the interval coverage accumulator.
// Holds the transaction structs, the region table entry, the controller
// state type and the command and status groups. Depends on nothing.
package icov_pkg;

  // Region table sizing
  localparam int MAX_REGIONS = 1024;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int USED_W      = IDX_W + 1;

  // Field widths
  localparam int CONTIG_W = 16;
  localparam int POS_W    = 31;
  localparam int LEN_W    = 16;
  localparam int RIDX_W   = 10;
  localparam int CNT_W    = 48;
  localparam int NCTG_W   = 17;
  localparam int CPOS_W   = POS_W + 1;

  localparam logic [NCTG_W-1:0] NUM_CONTIGS_RST = NCTG_W'(65536);

  // Request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_RBACK  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [CONTIG_W-1:0] contig_id;
    logic [POS_W-1:0]    pos_start;
    logic [POS_W-1:0]    region_end_pos;
    logic [LEN_W-1:0]    read_len;
    logic [RIDX_W-1:0]   region_index;
  } icov_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [CONTIG_W-1:0] out_contig;
    logic [POS_W-1:0]    out_start;
    logic [POS_W-1:0]    out_end;
    logic [CNT_W-1:0]    out_count;
  } icov_res_t;

  typedef struct packed {
    logic [CONTIG_W-1:0] contig;
    logic [POS_W-1:0]    start_pos;
    logic [POS_W-1:0]    end_pos;
    logic [CNT_W-1:0]    count;
  } icov_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_OVL,
    S_ADD,
    S_RESP
  } icov_state_e;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       append_wr;
    logic       rback_rd;
    logic       walk_init;
    logic       walk_rd;
    logic       walk_inc;
    logic       ld_bounds;
    logic       ld_ov;
    logic       acc_wr;
    logic       set_status;
    logic [1:0] status;
    logic       rback_ok;
    logic       load_out;
  } icov_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       contig_ign;
    logic       full;
    logic       idx_bad;
    logic       walk_end;
    logic       mismatch;
    logic       skip;
    logic       stop;
    logic       out_free;
  } icov_sts_t;

endpackage

[src/icov_ctrl.sv]
// Controller state machine for the interval coverage accumulator.
// Decodes requests, sequences the table walk and hands off results.
// Depends on icov_pkg.
module icov_ctrl import icov_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  icov_sts_t sts_i,
  output icov_cmd_t cmd_o
);

  icov_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture    = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_OK;
          state_d          = S_RESP;
          unique case (sts_i.req_type)
            REQ_APPEND: begin
              if (sts_i.contig_ign) begin
                cmd_o.status = ST_IGNORED;
              end else if (sts_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.append_wr = 1'b1;
              end
            end
            REQ_READ: begin
              if (sts_i.contig_ign) begin
                cmd_o.status = ST_IGNORED;
              end else begin
                cmd_o.walk_init = 1'b1;
                state_d         = S_FETCH;
              end
            end
            REQ_RBACK: begin
              if (sts_i.idx_bad) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.rback_rd = 1'b1;
                cmd_o.rback_ok = 1'b1;
              end
            end
            default: begin
              cmd_o.status = ST_OK;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (sts_i.walk_end) begin
          state_d = S_RESP;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.mismatch || sts_i.skip) begin
          cmd_o.walk_inc = 1'b1;
          state_d        = S_FETCH;
        end else if (sts_i.stop) begin
          state_d = S_RESP;
        end else begin
          cmd_o.ld_bounds = 1'b1;
          state_d         = S_OVL;
        end
      end
      S_OVL: begin
        cmd_o.ld_ov = 1'b1;
        state_d     = S_ADD;
      end
      S_ADD: begin
        cmd_o.acc_wr   = 1'b1;
        cmd_o.walk_inc = 1'b1;
        state_d        = S_FETCH;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[src/icov_dp.sv]
// Datapath for the interval coverage accumulator.
// Holds the region table memory, the fill count, the contig limit, the
// overlap arithmetic and the output register. Depends on icov_pkg.
module icov_dp import icov_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icov_req_t         in_data_i,
  input  logic              cfg_we_i,
  input  logic [NCTG_W-1:0] cfg_data_i,
  input  icov_cmd_t         cmd_i,
  output icov_sts_t         sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output icov_res_t         out_data_o
);

  icov_ent_t mem [MAX_REGIONS];

  logic [USED_W-1:0] used_q;
  logic [NCTG_W-1:0] num_contigs_q;
  logic              out_valid_q;
  icov_res_t         out_q;

  icov_req_t         req_q;
  logic [CPOS_W-1:0] re_q;
  logic [USED_W-1:0] idx_q;
  icov_ent_t         rdata_q;
  logic [CPOS_W-1:0] hi_q;
  logic [CPOS_W-1:0] lo_q;
  logic [CPOS_W-1:0] ov_q;
  logic [1:0]        status_q;
  logic              rback_q;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  icov_ent_t         mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  logic [CPOS_W-1:0] rs;
  logic [CPOS_W-1:0] ent_s;
  logic [CPOS_W-1:0] ent_e;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  new_cnt;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q        <= '0;
      num_contigs_q <= NUM_CONTIGS_RST;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_contigs_q <= cfg_data_i;
      end
      if (cmd_i.append_wr) begin
        used_q <= used_q + USED_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk operands
  assign rs    = {1'b0, req_q.pos_start};
  assign ent_s = {1'b0, rdata_q.start_pos};
  assign ent_e = {1'b0, rdata_q.end_pos};

  // Saturating accumulate
  assign sum     = {1'b0, rdata_q.count} + (CNT_W + 1)'(ov_q);
  assign new_cnt = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
      re_q  <= {1'b0, in_data_i.pos_start} + CPOS_W'(in_data_i.read_len);
    end
    if (cmd_i.walk_init) begin
      idx_q <= '0;
    end else if (cmd_i.walk_inc) begin
      idx_q <= idx_q + USED_W'(1);
    end
    if (cmd_i.ld_bounds) begin
      hi_q <= (ent_e < re_q) ? ent_e : re_q;
      lo_q <= (ent_s > rs) ? ent_s : rs;
    end
    if (cmd_i.ld_ov) begin
      ov_q <= (hi_q > lo_q) ? (hi_q - lo_q) : '0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
      rback_q  <= cmd_i.rback_ok;
    end
    if (cmd_i.load_out) begin
      out_q.status <= status_q;
      if (rback_q) begin
        out_q.out_contig <= rdata_q.contig;
        out_q.out_start  <= rdata_q.start_pos;
        out_q.out_end    <= rdata_q.end_pos;
        out_q.out_count  <= rdata_q.count;
      end else begin
        out_q.out_contig <= '0;
        out_q.out_start  <= '0;
        out_q.out_end    <= '0;
        out_q.out_count  <= '0;
      end
    end
  end

  // Table port select
  always_comb begin
    mem_we    = cmd_i.append_wr | cmd_i.acc_wr;
    mem_waddr = cmd_i.append_wr ? used_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
    if (cmd_i.append_wr) begin
      mem_wdata.contig    = in_data_i.contig_id;
      mem_wdata.start_pos = in_data_i.pos_start;
      mem_wdata.end_pos   = in_data_i.region_end_pos;
      mem_wdata.count     = '0;
    end else begin
      mem_wdata       = rdata_q;
      mem_wdata.count = new_cnt;
    end
    mem_re    = cmd_i.rback_rd | cmd_i.walk_rd;
    mem_raddr = cmd_i.rback_rd ? IDX_W'(in_data_i.region_index) : idx_q[IDX_W-1:0];
  end

  // Region table
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Status to controller
  always_comb begin
    sts_o.req_type   = in_data_i.req_type;
    sts_o.contig_ign = ({1'b0, in_data_i.contig_id} >= num_contigs_q);
    sts_o.full       = (32'(used_q) >= 32'(MAX_REGIONS));
    sts_o.idx_bad    = (32'(in_data_i.region_index) >= 32'(used_q));
    sts_o.walk_end   = (idx_q >= used_q);
    sts_o.mismatch   = (rdata_q.contig != req_q.contig_id);
    sts_o.skip       = (ent_e < rs);
    sts_o.stop       = (ent_s > re_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/interval_coverage_accumulator.sv]
// Top level of the interval coverage accumulator.
// Joins the controller and the datapath. Depends on icov_pkg, icov_ctrl
// and icov_dp.
//
// One transaction at a time is processed. Append, ignored and readback
// requests go from acceptance to S_RESP, which loads the result into the
// output register once it is free. A read walks the region table from entry
// 0: each entry that is skipped or on another contig passes S_FETCH and
// S_CHECK, each that gains coverage also S_OVL and S_ADD (read, bounds,
// overlap, read-modify-write of the count). The next request is taken once
// the result has moved to the output register, even while it is stalled.
// The user writes num_contigs through the cfg channel, which is always ready,
// only while the block is idle; the block itself does not enforce this.
module interval_coverage_accumulator import icov_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  icov_req_t         in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output icov_res_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [NCTG_W-1:0] cfg_data_i
);

  icov_cmd_t cmd;
  icov_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  icov_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table and arithmetic
  icov_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
